FILE: rtl/grc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the grid ray caster.
// No dependencies; grc_if, grid_ray_caster and grc_walk refer to this package.
package grc_pkg;

    // Request and result field widths.
    localparam int CELL_W  = 10;
    localparam int OCC_W   = 8;
    localparam int POSE_W  = 18;
    localparam int HEAD_W  = 12;
    localparam int BEAM_W  = 8;
    localparam int RANGE_W = 19;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_CELLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEAM_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKED   = 3'd4;

    // Request commands.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    // Angles in tenths of a degree.
    localparam int ANGLE_FULL    = 3600;
    localparam int ANGLE_HALF    = 1800;
    localparam int ANGLE_QUARTER = 900;
    localparam int ANGLE_OFFSET  = 2700;
    localparam int DEG_TENTHS    = 10;
    localparam int ANG_SUM_W     = 16;

    // Bhaskara sine: floor(p * 2^17 / (4050000 - p)), p = h * (1800 - h).
    localparam int BHASKARA_K = 4050000;
    localparam int SIN_SHIFT  = 17;
    localparam int SIN_P_W    = 20;
    localparam int SIN_NUM_W  = 37;
    localparam int SIN_DEN_W  = 22;
    localparam int Q15_SHIFT  = 15;
    localparam int TRIG_W     = 16;

    // Geometry.
    localparam int CELL_Q_W  = 14;
    localparam int CS_W      = 9;
    localparam int CS_MAX    = 496;
    localparam int MAP_BIT_W = 9;
    localparam int RANGE_MAX = 524287;

    // Register reset values.
    localparam logic [4:0]  RST_CELL_SIZE = 5'd10;
    localparam logic [10:0] RST_MAP_CELLS = 11'd800;
    localparam logic [7:0]  RST_FREE_THR  = 8'd2;
    localparam logic [3:0]  RST_BEAM_STEP = 4'd2;
    localparam logic [18:0] RST_BLOCKED   = 19'd80;

    typedef struct packed {
        logic [4:0]  cell_size_cm;
        logic [10:0] map_cells_in_use;
        logic [7:0]  free_threshold;
        logic [3:0]  beam_step_deg;
        logic [18:0] blocked_range;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_COS,
        ST_SIN,
        ST_CELL_X,
        ST_CELL_Y,
        ST_SETUP,
        ST_START,
        ST_STEP,
        ST_CHECK,
        ST_DIST,
        ST_FINISH
    } cast_state_t;

endpackage

FILE: rtl/grc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
// Depends on grc_pkg for the field widths.
interface grc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [grc_pkg::CELL_W-1:0]    cell_x;
    logic [grc_pkg::CELL_W-1:0]    cell_y;
    logic [grc_pkg::OCC_W-1:0]     occupancy;
    logic                          unknown_cell;
    logic [grc_pkg::POSE_W-1:0]    pose_x;
    logic [grc_pkg::POSE_W-1:0]    pose_y;
    logic [grc_pkg::HEAD_W-1:0]    heading;
    logic [grc_pkg::BEAM_W-1:0]    beam;

    modport source (
        output valid, cmd, cell_x, cell_y, occupancy, unknown_cell,
               pose_x, pose_y, heading, beam,
        input  ready
    );
    modport sink (
        input  valid, cmd, cell_x, cell_y, occupancy, unknown_cell,
               pose_x, pose_y, heading, beam,
        output ready
    );
endinterface

interface grc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [grc_pkg::BEAM_W-1:0]    beam_echo;
    logic [grc_pkg::RANGE_W-1:0]   range;
    logic                          outside_map;

    modport source (output valid, beam_echo, range, outside_map, input ready);
    modport sink (input valid, beam_echo, range, outside_map, output ready);
endinterface

FILE: rtl/grid_ray_caster.sv
`timescale 1ns / 1ps
// Occupancy-grid ray caster top level: configuration registers and the cast sequencer.
// Depends on grc_pkg, grc_if and grc_walk.
//
// A write request stores one map cell and returns no result. A cast request returns one
// result. Its divisions use the shared divider, one quotient bit per cycle, which is 37
// bits wide at MAP_SIDE = 1024. The cell walk is bounded by the single read port of the
// map memory, one read per step. Requests are taken one at a time; a finished result
// waits in the output register and the next request is accepted meanwhile. The map is
// not cleared by reset: every cell a cast may reach has to be written first. Configuration
// is to be written by the user only while idle; the block itself does not enforce this.
module grid_ray_caster #(
    parameter int MAP_SIDE = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]    cfg_data,
    grc_req_if.sink                           req,
    grc_rsp_if.source                         rsp
);

    grc_pkg::cfg_t cfg_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_size_cm     <= grc_pkg::RST_CELL_SIZE;
            cfg_reg.map_cells_in_use <= grc_pkg::RST_MAP_CELLS;
            cfg_reg.free_threshold   <= grc_pkg::RST_FREE_THR;
            cfg_reg.beam_step_deg    <= grc_pkg::RST_BEAM_STEP;
            cfg_reg.blocked_range    <= grc_pkg::RST_BLOCKED;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                grc_pkg::CFG_CELL_SIZE: cfg_reg.cell_size_cm     <= cfg_data[4:0];
                grc_pkg::CFG_MAP_CELLS: cfg_reg.map_cells_in_use <= cfg_data[10:0];
                grc_pkg::CFG_FREE_THR:  cfg_reg.free_threshold   <= cfg_data[7:0];
                grc_pkg::CFG_BEAM_STEP: cfg_reg.beam_step_deg    <= cfg_data[3:0];
                grc_pkg::CFG_BLOCKED:   cfg_reg.blocked_range    <= cfg_data[18:0];
                default:
                begin
                end
            endcase
        end
    end

    // Cast sequencer with map memory and divider.
    grc_walk #(
        .MAP_SIDE (MAP_SIDE)
    ) u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

FILE: rtl/grc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module grc_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/grc_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, shared by the sine, cell index and range steps of a cast.
// No dependencies.
module grc_div #(
    parameter int NUM_W = 37,
    parameter int DEN_W = 22
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   trial;

    // One shift and trial subtract per cycle.
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        trial     = shifted - {1'b0, den_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/grc_walk.sv
`timescale 1ns / 1ps
// Cast sequencer: map storage, trig and cell setup, and the DDA walk.
// Depends on grc_pkg, grc_if, grc_ram and grc_div.
module grc_walk #(
    parameter int MAP_SIDE = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  grc_pkg::cfg_t   cfg,
    grc_req_if.sink         req,
    grc_rsp_if.source       rsp
);

    localparam int N_W    = $clog2(MAP_SIDE + 1);
    localparam int CW     = N_W + 1;
    localparam int MW     = (N_W > 11) ? N_W : 11;
    localparam int QW     = (grc_pkg::CELL_Q_W > N_W) ? grc_pkg::CELL_Q_W : N_W;
    localparam int B_W    = $clog2(MAP_SIDE * grc_pkg::CS_MAX + (1 << grc_pkg::POSE_W) + 1);
    localparam int PW     = B_W + grc_pkg::TRIG_W;
    localparam int NUM_W  = (B_W + grc_pkg::Q15_SHIFT > grc_pkg::SIN_NUM_W)
                            ? B_W + grc_pkg::Q15_SHIFT : grc_pkg::SIN_NUM_W;
    localparam int DEN_W  = grc_pkg::SIN_DEN_W;
    localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int XW     = grc_pkg::CELL_Q_W + grc_pkg::CS_W;

    grc_pkg::cast_state_t state_reg, state_next;

    logic [grc_pkg::POSE_W-1:0]   px_reg, py_reg;
    logic [grc_pkg::HEAD_W-1:0]   head_reg;
    logic [grc_pkg::BEAM_W-1:0]   beam_reg;
    logic [11:0]                  ang_reg;
    logic [grc_pkg::TRIG_W-1:0]   ac_reg, as_reg;
    logic                         c_neg_reg, s_neg_reg;
    logic [grc_pkg::CELL_Q_W-1:0] cx_reg, cy_reg;
    logic [B_W-1:0]               bx_reg, by_reg, last_b_reg;
    logic                         last_x_reg;
    logic signed [CW-1:0]         x_reg, y_reg;
    logic [PW-1:0]                prod_x_reg, prod_y_reg;
    logic [grc_pkg::RANGE_W-1:0]  res_range_reg;
    logic                         res_outside_reg;
    logic                         issued_reg;
    logic                         rsp_valid_reg;
    logic [grc_pkg::BEAM_W-1:0]   rsp_beam_reg;
    logic [grc_pkg::RANGE_W-1:0]  rsp_range_reg;
    logic                         rsp_outside_reg;

    logic [4:0]                   c_eff;
    logic [grc_pkg::CS_W-1:0]     cs;
    logic [MW-1:0]                n_wide;
    logic [N_W-1:0]               n;
    logic [11:0]                  bs;
    logic [grc_pkg::ANG_SUM_W-1:0] ang_sum;
    logic [grc_pkg::ANG_SUM_W-1:0] ang_w;
    logic [11:0]                  ang_mod;
    logic [12:0]                  cos_sum;
    logic [11:0]                  sin_a;
    logic                         sin_half;
    logic [10:0]                  sin_h;
    logic [grc_pkg::SIN_P_W-1:0]  sin_p;
    logic                         div_state;
    logic                         div_start;
    logic [NUM_W-1:0]             div_num;
    logic [DEN_W-1:0]             div_den;
    logic                         div_done;
    logic [NUM_W-1:0]             div_q;
    logic                         accept;
    logic                         out_load;
    logic                         outside;
    logic [XW-1:0]                xcs, ycs;
    logic [B_W-1:0]               bx_init, by_init;
    logic                         step_x;
    logic signed [CW-1:0]         nx, ny;
    logic                         leave;
    logic                         start_stop;
    logic                         cell_stop;
    logic                         ram_we;
    logic [ADDR_W-1:0]            ram_waddr;
    logic [grc_pkg::MAP_BIT_W-1:0] ram_wdata;
    logic                         ram_re;
    logic [ADDR_W-1:0]            ram_raddr;
    logic [grc_pkg::MAP_BIT_W-1:0] ram_rdata;

    // Effective configuration.
    always_comb
    begin
        c_eff  = (cfg.cell_size_cm == 5'd0) ? 5'd1 : cfg.cell_size_cm;
        cs     = {c_eff, 4'b0000};
        n_wide = (MW'(cfg.map_cells_in_use) > MW'(MAP_SIDE))
                 ? MW'(MAP_SIDE) : MW'(cfg.map_cells_in_use);
        n      = N_W'(n_wide);
    end

    // Beam angle, wrapped to one turn by conditional subtraction of 8, 4, 2 and 1 turns,
    // and the sine argument for cos or sin.
    always_comb
    begin
        bs       = 12'(beam_reg) * 12'(cfg.beam_step_deg);
        ang_sum  = grc_pkg::ANG_SUM_W'(head_reg) + grc_pkg::ANG_SUM_W'(grc_pkg::ANGLE_OFFSET)
                   + grc_pkg::ANG_SUM_W'(bs) * grc_pkg::ANG_SUM_W'(grc_pkg::DEG_TENTHS);
        ang_w    = ang_sum;
        for (int k = 3; k >= 0; k--)
        begin
            if (ang_w >= grc_pkg::ANG_SUM_W'(grc_pkg::ANGLE_FULL << k))
            begin
                ang_w = ang_w - grc_pkg::ANG_SUM_W'(grc_pkg::ANGLE_FULL << k);
            end
        end
        ang_mod  = ang_w[11:0];
        cos_sum  = 13'(ang_reg) + 13'(grc_pkg::ANGLE_QUARTER);
        if (state_reg == grc_pkg::ST_COS)
        begin
            sin_a = (cos_sum >= 13'(grc_pkg::ANGLE_FULL))
                    ? 12'(cos_sum - 13'(grc_pkg::ANGLE_FULL)) : 12'(cos_sum);
        end
        else
        begin
            sin_a = ang_reg;
        end
        sin_half = (sin_a >= 12'(grc_pkg::ANGLE_HALF));
        sin_h    = sin_half ? 11'(sin_a - 12'(grc_pkg::ANGLE_HALF)) : 11'(sin_a);
        sin_p    = grc_pkg::SIN_P_W'(sin_h)
                   * grc_pkg::SIN_P_W'(11'(grc_pkg::ANGLE_HALF) - sin_h);
    end

    // Divider operand selection by sequencer state.
    always_comb
    begin
        div_state = (state_reg inside {grc_pkg::ST_COS, grc_pkg::ST_SIN,
                                       grc_pkg::ST_CELL_X, grc_pkg::ST_CELL_Y,
                                       grc_pkg::ST_DIST});
        div_start = div_state && !issued_reg;
        case (state_reg)
            grc_pkg::ST_COS, grc_pkg::ST_SIN:
            begin
                div_num = NUM_W'(sin_p) << grc_pkg::SIN_SHIFT;
                div_den = DEN_W'(grc_pkg::BHASKARA_K) - DEN_W'(sin_p);
            end
            grc_pkg::ST_CELL_X:
            begin
                div_num = NUM_W'(px_reg[grc_pkg::POSE_W-1:4]);
                div_den = DEN_W'(c_eff);
            end
            grc_pkg::ST_CELL_Y:
            begin
                div_num = NUM_W'(py_reg[grc_pkg::POSE_W-1:4]);
                div_den = DEN_W'(c_eff);
            end
            grc_pkg::ST_DIST:
            begin
                div_num = NUM_W'(last_b_reg) << grc_pkg::Q15_SHIFT;
                div_den = last_x_reg ? DEN_W'(ac_reg) : DEN_W'(as_reg);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    // Start cell and boundary distances of the origin.
    always_comb
    begin
        outside = (QW'(cx_reg) >= QW'(n)) || (QW'(cy_reg) >= QW'(n));
        xcs     = XW'(cx_reg) * XW'(cs);
        ycs     = XW'(cy_reg) * XW'(cs);
        bx_init = c_neg_reg ? B_W'(XW'(px_reg) - xcs) : B_W'(xcs + XW'(cs) - XW'(px_reg));
        by_init = s_neg_reg ? B_W'(XW'(py_reg) - ycs) : B_W'(ycs + XW'(cs) - XW'(py_reg));
    end

    // DDA step: nearer boundary wins, a tie goes to the y boundary.
    always_comb
    begin
        if (ac_reg == '0)
        begin
            step_x = 1'b0;
        end
        else if (as_reg == '0)
        begin
            step_x = 1'b1;
        end
        else
        begin
            step_x = (prod_x_reg < prod_y_reg);
        end
        nx = x_reg;
        ny = y_reg;
        if (step_x)
        begin
            nx = c_neg_reg ? x_reg - CW'(1) : x_reg + CW'(1);
        end
        else
        begin
            ny = s_neg_reg ? y_reg - CW'(1) : y_reg + CW'(1);
        end
        leave = nx[CW-1] || ny[CW-1]
                || (nx >= $signed({1'b0, n})) || (ny >= $signed({1'b0, n}));
    end

    // Map cell tests on the registered read data.
    always_comb
    begin
        start_stop = !ram_rdata[grc_pkg::OCC_W]
                     && (ram_rdata[grc_pkg::OCC_W-1:0] > cfg.free_threshold);
        cell_stop  = ram_rdata[grc_pkg::OCC_W]
                     || (ram_rdata[grc_pkg::OCC_W-1:0] > cfg.free_threshold);
    end

    // Handshake and map port control.
    always_comb
    begin
        req.ready = (state_reg == grc_pkg::ST_IDLE);
        accept    = req.valid && req.ready;
        out_load  = (state_reg == grc_pkg::ST_FINISH) && (!rsp_valid_reg || rsp.ready);
        ram_we    = accept && (req.cmd == grc_pkg::CMD_WRITE)
                    && (32'(req.cell_x) < MAP_SIDE) && (32'(req.cell_y) < MAP_SIDE);
        ram_waddr = ADDR_W'(req.cell_y) * ADDR_W'(MAP_SIDE) + ADDR_W'(req.cell_x);
        ram_wdata = {req.unknown_cell, req.occupancy};
        if (state_reg == grc_pkg::ST_SETUP)
        begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(cy_reg) * ADDR_W'(MAP_SIDE) + ADDR_W'(cx_reg);
        end
        else
        begin
            ram_re    = (state_reg == grc_pkg::ST_STEP) && !leave;
            ram_raddr = ADDR_W'(ny[CW-2:0]) * ADDR_W'(MAP_SIDE) + ADDR_W'(nx[CW-2:0]);
        end
        rsp.valid       = rsp_valid_reg;
        rsp.beam_echo   = rsp_beam_reg;
        rsp.range       = rsp_range_reg;
        rsp.outside_map = rsp_outside_reg;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            grc_pkg::ST_IDLE:
            begin
                if (accept && (req.cmd == grc_pkg::CMD_CAST))
                begin
                    state_next = grc_pkg::ST_ANGLE;
                end
            end
            grc_pkg::ST_ANGLE:  state_next = grc_pkg::ST_COS;
            grc_pkg::ST_COS:    if (div_done) state_next = grc_pkg::ST_SIN;
            grc_pkg::ST_SIN:    if (div_done) state_next = grc_pkg::ST_CELL_X;
            grc_pkg::ST_CELL_X: if (div_done) state_next = grc_pkg::ST_CELL_Y;
            grc_pkg::ST_CELL_Y: if (div_done) state_next = grc_pkg::ST_SETUP;
            grc_pkg::ST_SETUP:
            begin
                state_next = outside ? grc_pkg::ST_FINISH : grc_pkg::ST_START;
            end
            grc_pkg::ST_START:
            begin
                state_next = start_stop ? grc_pkg::ST_FINISH : grc_pkg::ST_STEP;
            end
            grc_pkg::ST_STEP:
            begin
                state_next = leave ? grc_pkg::ST_DIST : grc_pkg::ST_CHECK;
            end
            grc_pkg::ST_CHECK:
            begin
                state_next = cell_stop ? grc_pkg::ST_DIST : grc_pkg::ST_STEP;
            end
            grc_pkg::ST_DIST:   if (div_done) state_next = grc_pkg::ST_FINISH;
            grc_pkg::ST_FINISH: if (out_load) state_next = grc_pkg::ST_IDLE;
            default:            state_next = grc_pkg::ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= grc_pkg::ST_IDLE;
            issued_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start)
            begin
                issued_reg <= 1'b1;
            end
            else if (div_done)
            begin
                issued_reg <= 1'b0;
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Cast datapath.
    always_ff @(posedge clk)
    begin
        prod_x_reg <= PW'(bx_reg) * PW'(as_reg);
        prod_y_reg <= PW'(by_reg) * PW'(ac_reg);
        if (accept && (req.cmd == grc_pkg::CMD_CAST))
        begin
            px_reg   <= req.pose_x;
            py_reg   <= req.pose_y;
            head_reg <= req.heading;
            beam_reg <= req.beam;
        end
        if (state_reg == grc_pkg::ST_ANGLE)
        begin
            ang_reg <= ang_mod;
        end
        if (div_done)
        begin
            case (state_reg)
                grc_pkg::ST_COS:
                begin
                    ac_reg    <= div_q[grc_pkg::TRIG_W-1:0];
                    c_neg_reg <= sin_half && (div_q != '0);
                end
                grc_pkg::ST_SIN:
                begin
                    as_reg    <= div_q[grc_pkg::TRIG_W-1:0];
                    s_neg_reg <= sin_half && (div_q != '0);
                end
                grc_pkg::ST_CELL_X: cx_reg <= div_q[grc_pkg::CELL_Q_W-1:0];
                grc_pkg::ST_CELL_Y: cy_reg <= div_q[grc_pkg::CELL_Q_W-1:0];
                grc_pkg::ST_DIST:
                begin
                    if (div_q == '0)
                    begin
                        res_range_reg <= cfg.blocked_range;
                    end
                    else if (div_q > NUM_W'(grc_pkg::RANGE_MAX))
                    begin
                        res_range_reg <= grc_pkg::RANGE_W'(grc_pkg::RANGE_MAX);
                    end
                    else
                    begin
                        res_range_reg <= div_q[grc_pkg::RANGE_W-1:0];
                    end
                    res_outside_reg <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == grc_pkg::ST_SETUP)
        begin
            x_reg           <= CW'(cx_reg);
            y_reg           <= CW'(cy_reg);
            bx_reg          <= bx_init;
            by_reg          <= by_init;
            res_range_reg   <= '0;
            res_outside_reg <= 1'b1;
        end
        if ((state_reg == grc_pkg::ST_START) && start_stop)
        begin
            res_range_reg   <= cfg.blocked_range;
            res_outside_reg <= 1'b0;
        end
        if (state_reg == grc_pkg::ST_STEP)
        begin
            x_reg      <= nx;
            y_reg      <= ny;
            last_x_reg <= step_x;
            if (step_x)
            begin
                last_b_reg <= bx_reg;
                bx_reg     <= bx_reg + B_W'(cs);
            end
            else
            begin
                last_b_reg <= by_reg;
                by_reg     <= by_reg + B_W'(cs);
            end
        end
        if (out_load)
        begin
            rsp_beam_reg    <= beam_reg;
            rsp_range_reg   <= res_range_reg;
            rsp_outside_reg <= res_outside_reg;
        end
    end

    // Occupancy map: bit 8 marks unknown, bits 7..0 hold the occupancy.
    grc_ram #(
        .WIDTH (grc_pkg::MAP_BIT_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared divider for sine, cell index and final range.
    grc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

endmodule
